// File: rtl/wstd_pkg.sv
// ----------------------------------------------------------------------------
// wstd_pkg: shared types, constants and helpers
// sizes, action codes, the storage command bundle and the time arithmetic
// used by the weighted server task dispatcher
// ----------------------------------------------------------------------------
package wstd_pkg;

  localparam int SERVERS   = 16;
  localparam int TIME_BITS = 48;
  localparam int IDX_W     = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int ACT_W     = 5;
  localparam int ACTION_W  = 2;
  localparam int SEL_W     = 4;
  localparam int WEIGHT_W  = 20;
  localparam int DUR_W     = 20;
  localparam int SRV_W     = 4;
  localparam int CNT_W     = 32;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  localparam logic [63:0] TIME_MAX64 = {64{1'b1}} >> (64 - TIME_BITS);

  // action codes
  localparam logic [ACTION_W-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SUBMIT  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [WEIGHT_W-1:0]  weight_t;
  typedef logic [IDX_W-1:0]     idx_t;

  // write commands from the sequencer to the server file
  typedef struct packed {
    logic    ld_en;
    idx_t    ld_sel;
    weight_t ld_weight;
    logic    clr_all;
    logic    book_en;
    idx_t    book_sel;
    time_t   book_time;
  } srv_cmd_t;

  // start plus duration, saturating at the top of the time range
  function automatic time_t sat_add(time_t a, logic [DUR_W-1:0] d);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + (TIME_BITS + 1)'(d);
    return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

  // arrival time of a task from the task count, clipped to the time range
  function automatic time_t arrive_time(logic [CNT_W-1:0] c);
    logic [63:0] c64;
    c64 = 64'(c);
    if (c64 > TIME_MAX64) begin
      c64 = TIME_MAX64;
    end
    return TIME_BITS'(c64);
  endfunction

  // number of servers taking part, zero acts as one, large values clip
  function automatic logic [ACT_W-1:0] act_count(logic [ACT_W-1:0] a);
    logic [ACT_W-1:0] n;
    n = a;
    if (a == '0) begin
      n = ACT_W'(1);
    end else if (32'(a) > SERVERS) begin
      n = ACT_W'(SERVERS);
    end
    return n;
  endfunction

endpackage

// File: rtl/wstd_tcmp.sv
// ----------------------------------------------------------------------------
// wstd_tcmp: shared time comparator
// unsigned less-than on two time values, reused by every scan step
// ----------------------------------------------------------------------------
module wstd_tcmp (
  input  wstd_pkg::time_t a,
  input  wstd_pkg::time_t b,
  output logic            lt
);

  assign lt = (a < b);

endmodule

// File: rtl/wstd_srv.sv
// ----------------------------------------------------------------------------
// wstd_srv: server file
// per-server weight and free time, with valid bits that make an unbooked
// free time read as zero; reads are registered
// ----------------------------------------------------------------------------
module wstd_srv (
  input  logic               clk,
  input  logic               rst_n,
  input  wstd_pkg::srv_cmd_t cmd,
  input  wstd_pkg::idx_t     rd_idx,
  output wstd_pkg::weight_t  rd_weight,
  output wstd_pkg::time_t    rd_free
);

  wstd_pkg::weight_t               weight_r [wstd_pkg::SERVERS];
  wstd_pkg::time_t                 free_r   [wstd_pkg::SERVERS];
  logic [wstd_pkg::SERVERS-1:0]    valid_r;
  logic [wstd_pkg::SERVERS-1:0]    valid_nxt;
  wstd_pkg::weight_t               rd_weight_r;
  wstd_pkg::time_t                 rd_free_r;

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.clr_all) begin
      valid_nxt = '0;
    end else if (cmd.ld_en) begin
      valid_nxt[cmd.ld_sel] = 1'b0;
    end else if (cmd.book_en) begin
      valid_nxt[cmd.book_sel] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_en) begin
      weight_r[cmd.ld_sel] <= cmd.ld_weight;
    end
    if (cmd.book_en) begin
      free_r[cmd.book_sel] <= cmd.book_time;
    end
  end

  // registered read, the address is the sequencer's next scan index
  always_ff @(posedge clk) begin
    rd_weight_r <= weight_r[rd_idx];
    rd_free_r   <= valid_r[rd_idx] ? free_r[rd_idx] : '0;
  end

  assign rd_weight = rd_weight_r;
  assign rd_free   = rd_free_r;

  ap_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.book_en && (cmd.ld_en || cmd.clr_all)))
    else $error("booking collides with a load or restart");

  ap_book_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.book_en |=> valid_r[$past(cmd.book_sel)])
    else $error("booked server not marked valid");

  ap_clr_all: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_all |=> valid_r == '0)
    else $error("restart left a booked free time");

endmodule

// File: rtl/wstd_ctrl.sv
// ----------------------------------------------------------------------------
// wstd_ctrl: dispatch sequencer
// runs the two server scans of a task through the shared time comparator
// and handles load and restart items
// ----------------------------------------------------------------------------
module wstd_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [wstd_pkg::ACTION_W-1:0]       in_action,
  input  logic [wstd_pkg::SEL_W-1:0]          in_sel,
  input  wstd_pkg::weight_t                   in_weight,
  input  logic [wstd_pkg::DUR_W-1:0]          in_dur,
  input  logic [wstd_pkg::ACT_W-1:0]          active,
  output wstd_pkg::srv_cmd_t                  cmd,
  output wstd_pkg::idx_t                      rd_idx,
  input  wstd_pkg::weight_t                   rd_weight,
  input  wstd_pkg::time_t                     rd_free,
  output logic                                res_valid,
  input  logic                                res_ready,
  output wstd_pkg::idx_t                      res_server,
  output wstd_pkg::time_t                     res_start
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MIN  = 5'b00010,
    S_ADJ  = 5'b00100,
    S_PICK = 5'b01000,
    S_BOOK = 5'b10000
  } state_t;

  state_t                          state_r, state_nxt;
  wstd_pkg::idx_t                  idx_r, idx_nxt;
  wstd_pkg::time_t                 now_r, now_nxt;
  wstd_pkg::time_t                 earliest_r, earliest_nxt;
  wstd_pkg::idx_t                  best_r, best_nxt;
  wstd_pkg::weight_t               best_w_r, best_w_nxt;
  logic                            found_r, found_nxt;
  logic [wstd_pkg::DUR_W-1:0]      dur_r, dur_nxt;
  logic [wstd_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [wstd_pkg::ACT_W-1:0]      n_r, n_nxt;
  logic                            done_r, done_nxt;

  wstd_pkg::time_t                 cmp_a, cmp_b;
  wstd_pkg::time_t                 arrive;
  logic                            cmp_lt;
  logic                            last;
  logic                            accept;

  wstd_tcmp u_tcmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt)
  );

  assign arrive   = wstd_pkg::arrive_time(count_r);
  assign last     = (wstd_pkg::ACT_W'(idx_r) == n_r - wstd_pkg::ACT_W'(1));
  assign in_ready = (state_r == S_IDLE) && !done_r;
  assign accept   = in_valid && in_ready;
  // read address is the next scan index, the server file registers the read
  assign rd_idx   = idx_nxt;

  // operand select for the shared comparator
  always_comb begin
    case (state_r)
      S_IDLE: begin
        cmp_a = now_r;
        cmp_b = arrive;
      end
      S_MIN: begin
        cmp_a = rd_free;
        cmp_b = earliest_r;
      end
      S_ADJ: begin
        cmp_a = now_r;
        cmp_b = earliest_r;
      end
      S_PICK: begin
        cmp_a = now_r;
        cmp_b = rd_free;
      end
      default: begin
        cmp_a = now_r;
        cmp_b = now_r;
      end
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    now_nxt      = now_r;
    earliest_nxt = earliest_r;
    best_nxt     = best_r;
    best_w_nxt   = best_w_r;
    found_nxt    = found_r;
    dur_nxt      = dur_r;
    count_nxt    = count_r;
    n_nxt        = n_r;
    done_nxt     = done_r;
    cmd          = '0;

    case (state_r)
      S_IDLE: begin
        if (done_r) begin
          if (res_ready) begin
            done_nxt = 1'b0;
          end
        end else if (accept) begin
          case (in_action)
            wstd_pkg::ACT_LOAD: begin
              if (32'(in_sel) < wstd_pkg::SERVERS) begin
                cmd.ld_en     = 1'b1;
                cmd.ld_sel    = wstd_pkg::IDX_W'(in_sel);
                cmd.ld_weight = in_weight;
              end
            end
            wstd_pkg::ACT_RESTART: begin
              cmd.clr_all = 1'b1;
              now_nxt     = '0;
              count_nxt   = '0;
            end
            wstd_pkg::ACT_SUBMIT: begin
              if (cmp_lt) begin
                now_nxt = arrive;
              end
              dur_nxt      = in_dur;
              n_nxt        = wstd_pkg::act_count(active);
              idx_nxt      = '0;
              earliest_nxt = '1;
              state_nxt    = S_MIN;
            end
            default: begin
            end
          endcase
        end
      end
      // first pass: earliest free time among active servers
      S_MIN: begin
        if (cmp_lt) begin
          earliest_nxt = rd_free;
        end
        if (last) begin
          state_nxt = S_ADJ;
        end else begin
          idx_nxt = idx_r + wstd_pkg::IDX_W'(1);
        end
      end
      // no server free yet: move time to the earliest free time
      S_ADJ: begin
        if (cmp_lt) begin
          now_nxt = earliest_r;
        end
        idx_nxt   = '0;
        found_nxt = 1'b0;
        state_nxt = S_PICK;
      end
      // second pass: free server with the smallest weight, lowest index on ties
      S_PICK: begin
        if (!cmp_lt && (!found_r || (rd_weight < best_w_r))) begin
          best_nxt   = idx_r;
          best_w_nxt = rd_weight;
          found_nxt  = 1'b1;
        end
        if (last) begin
          state_nxt = S_BOOK;
        end else begin
          idx_nxt = idx_r + wstd_pkg::IDX_W'(1);
        end
      end
      S_BOOK: begin
        cmd.book_en   = 1'b1;
        cmd.book_sel  = best_r;
        cmd.book_time = wstd_pkg::sat_add(now_r, dur_r);
        if (count_r != '1) begin
          count_nxt = count_r + wstd_pkg::CNT_W'(1);
        end
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_valid  = (state_r == S_IDLE) && done_r;
  assign res_server = best_r;
  assign res_start  = now_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      now_r   <= '0;
      count_r <= '0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      now_r   <= now_nxt;
      count_r <= count_nxt;
      done_r  <= done_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    earliest_r <= earliest_nxt;
    best_r     <= best_nxt;
    best_w_r   <= best_w_nxt;
    dur_r      <= dur_nxt;
    n_r        <= n_nxt;
  end

  ap_found: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BOOK |-> found_r)
    else $error("booking without a free server");

  ap_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MIN || state_r == S_PICK) |-> wstd_pkg::ACT_W'(idx_r) < n_r)
    else $error("scan index beyond active servers");

  ap_now_mono: assert property (@(posedge clk) disable iff (!rst_n)
    !(accept && in_action == wstd_pkg::ACT_RESTART) |=> now_r >= $past(now_r))
    else $error("current time moved backward");

  ap_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BOOK |=>
      (count_r == $past(count_r) + wstd_pkg::CNT_W'(1)) || ($past(count_r) == '1))
    else $error("task count not advanced");

endmodule

// File: rtl/weighted_server_task_dispatch_top.sv
// ----------------------------------------------------------------------------
// weighted_server_task_dispatch_top: weighted server task dispatcher
// assigns each submitted task to the free server of least weight and
// reports the server and start time
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   in_       slave      in_tvalid/in_tready    tuser: action; tdata: sel, weight, duration
//   out_      master     out_tvalid/out_tready  tdata: server, start_time
//   cfg_      write      cfg_we                 cfg_wdata: active_servers
//
// - a submitted task runs two scans over the n active servers, one compare
//   per cycle in each, then one time adjust step and one booking step; the
//   scans and the time adjust step share one comparator
// - load, restart and unused action items are done at accept, without a scan
// - reset: synchronous on rst_n low; clears time, task count, free times
//   (through valid bits) and sets active_servers to one; weights stay unset
// - the finished item sits in the output register, so the next item is
//   accepted while a result still waits on out_tready; a new result waits
//   in the sequencer until that register frees up
// ----------------------------------------------------------------------------
module weighted_server_task_dispatch_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input items
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [wstd_pkg::IN_TDATA_W-1:0]      in_tdata,   // server_sel, weight, duration
  input  logic [wstd_pkg::ACTION_W-1:0]        in_tuser,   // action
  // result items
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [wstd_pkg::OUT_TDATA_W-1:0]     out_tdata,  // server, start_time
  // configuration
  input  logic                                 cfg_we,
  input  logic [wstd_pkg::ACT_W-1:0]           cfg_wdata   // active_servers
);

  localparam int SEL_LO = 0;
  localparam int WGT_LO = SEL_LO + wstd_pkg::SEL_W;
  localparam int DUR_LO = WGT_LO + wstd_pkg::WEIGHT_W;
  localparam int OUT_PAD = wstd_pkg::OUT_TDATA_W - wstd_pkg::SRV_W - wstd_pkg::TIME_BITS;

  logic [wstd_pkg::ACT_W-1:0]        active_r;
  logic                              out_valid_r;
  logic [wstd_pkg::OUT_TDATA_W-1:0]  out_data_r;

  wstd_pkg::srv_cmd_t   cmd;
  wstd_pkg::idx_t       rd_idx;
  wstd_pkg::weight_t    rd_weight;
  wstd_pkg::time_t      rd_free;
  logic                 res_valid;
  logic                 res_ready;
  wstd_pkg::idx_t       res_server;
  wstd_pkg::time_t      res_start;

  // active server count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= wstd_pkg::ACT_W'(1);
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
    end
  end

  wstd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_action  (in_tuser),
    .in_sel     (in_tdata[WGT_LO-1:SEL_LO]),
    .in_weight  (in_tdata[DUR_LO-1:WGT_LO]),
    .in_dur     (in_tdata[DUR_LO+wstd_pkg::DUR_W-1:DUR_LO]),
    .active     (active_r),
    .cmd        (cmd),
    .rd_idx     (rd_idx),
    .rd_weight  (rd_weight),
    .rd_free    (rd_free),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_server (res_server),
    .res_start  (res_start)
  );

  wstd_srv u_srv (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .rd_idx    (rd_idx),
    .rd_weight (rd_weight),
    .rd_free   (rd_free)
  );

  // output register, refilled as soon as the previous item is taken
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= {{OUT_PAD{1'b0}}, res_start, wstd_pkg::SRV_W'(res_server)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  ap_res_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> out_tvalid)
    else $error("finished item not loaded into output register");

  ap_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |-> !in_tready)
    else $error("input taken while a result is blocked");

  ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("output item changed while stalled");

endmodule
